>>> src/stp_pkg.sv
// Shared types, constants and the sine table for the sine PWM level generator.
// No dependencies; every other file of the block depends on this package.
`default_nettype none

package stp_pkg;

    // Field widths fixed by the item formats
    localparam int KIND_W     = 2;
    localparam int CH_W       = 4;
    localparam int AMP_W      = 10;
    localparam int DUTY_W     = 10;
    localparam int IDX_W      = 6;
    localparam int PULSE_W    = 7;
    localparam int DIV_W      = 12;
    localparam int SAMPLE_W   = 11;
    localparam int PROD_W     = AMP_W + SAMPLE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int TABLE_SIZE = 64;
    localparam int PAIR_COUNT = 6;
    localparam int PAIR_IDX_W = 3;
    localparam int MID_LEVEL  = 500;
    localparam int DUTY_MAX   = 1023;

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SYNC = 2'd1;
    localparam logic [KIND_W-1:0] KIND_AMP  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_LOAD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_START = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR0    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR1    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR2    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR3    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR4    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR5    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIVS,
        ST_DIVW,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                     start;
        logic signed [PROD_W-1:0] dividend;
        logic [DIV_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [PROD_W-1:0] quotient;
    } div_rsp_t;

    // First quadrant of trunc(512*sin(2*pi*n/64)), n = 0..16
    localparam logic [9:0] QUARTER [17] = '{
        10'd0,   10'd50,  10'd99,  10'd148, 10'd195, 10'd241,
        10'd284, 10'd324, 10'd362, 10'd395, 10'd425, 10'd451,
        10'd473, 10'd489, 10'd502, 10'd509, 10'd512
    };

    // Fold the phase index onto the quarter table
    function automatic logic signed [SAMPLE_W-1:0] sine_sample(input logic [IDX_W-1:0] idx);
        logic [1:0]                 quad;
        logic [4:0]                 k;
        logic signed [SAMPLE_W-1:0] mag;
        quad = idx[5:4];
        k    = quad[0] ? (5'd16 - {1'b0, idx[3:0]}) : {1'b0, idx[3:0]};
        mag  = $signed({1'b0, QUARTER[k]});
        return quad[1] ? -mag : mag;
    endfunction

endpackage

`default_nettype wire

>>> src/stp_if.sv
// Handshake channels of the sine PWM level generator: command beats in, level beats out.
// Depends on stp_pkg for field widths.
`default_nettype none

interface stp_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [stp_pkg::KIND_W-1:0]         kind;
    logic [stp_pkg::CH_W-1:0]           channel;
    logic signed [stp_pkg::AMP_W-1:0]   amplitude;

    modport source (output valid, kind, channel, amplitude, input ready);
    modport sink   (input valid, kind, channel, amplitude, output ready);
endinterface

interface stp_lvl_if;
    logic                        valid;
    logic                        ready;
    logic [stp_pkg::CH_W-1:0]    out_channel;
    logic [stp_pkg::DUTY_W-1:0]  duty;
    logic                        sync_level;
    logic                        last;

    modport source (output valid, out_channel, duty, sync_level, last, input ready);
    modport sink   (input valid, out_channel, duty, sync_level, last, output ready);
endinterface

`default_nettype wire

>>> src/sine_table_multichannel_pwm_levels.sv
// Top level of the sine PWM level generator: sequencer, state and output register.
// Depends on stp_pkg, the channel interfaces in stp_if.sv and the divider stp_div.
//
//  channel | direction | beat carries
//  --------+-----------+--------------------------------------------------
//  cmd     | in        | kind, channel, amplitude (tick, sync edge, amp write)
//  lvl     | out       | out_channel, duty, sync_level, last
//  cfg     | in        | cfg_we, cfg_index, cfg_data (write only)
//
// A sync edge, an amplitude write or an unused kind is handled in the idle step.
// A tick works through the channels in turn, each by multiply, divider start, one
// divider step per quotient bit, wait and emit; the bit-serial divider sets the pace.
// cmd.ready is high only while the sequencer is idle; the last level of a tick may
// still wait in the output register while the next command is taken.
// A stalled lvl holds the sequencer in its emit step. Reset needs no clearing pass.
`default_nettype none

module sine_table_multichannel_pwm_levels #(
    parameter int CHANNELS = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    stp_cmd_if.sink                              cmd,
    stp_lvl_if.source                            lvl,
    input  wire logic                            cfg_we,
    input  wire logic [stp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [stp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stp_pkg::*;

    localparam int CH_IDX_W = $clog2(CHANNELS);

    // Sequencer
    state_t state_reg, state_next;

    // Configuration registers
    logic [IDX_W-1:0]   sync_load_reg;
    logic [PULSE_W-1:0] pulse_start_reg;
    logic [DIV_W-1:0]   divisor_reg [PAIR_COUNT];

    // Block state
    logic [IDX_W-1:0]        phase_reg;
    logic signed [AMP_W-1:0] amp_reg [CHANNELS];

    // Per-tick working registers
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       sync_reg;
    logic [CH_IDX_W-1:0]        ch_reg;
    logic signed [PROD_W-1:0]   prod_reg;

    // Output register
    logic              out_valid_reg;
    logic [CH_W-1:0]   out_channel_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_sync_reg;
    logic              out_last_reg;

    logic                     cmd_fire;
    logic                     load_out;
    logic                     ch_is_last;
    logic [PAIR_IDX_W-1:0]    pair_idx;
    logic [DIV_W-1:0]         divisor_sel;
    logic signed [PROD_W-1:0] product;
    logic signed [PROD_W:0]   level_sum;
    logic [DUTY_W-1:0]        duty_sat;
    div_req_t                 div_req;
    div_rsp_t                 div_rsp;

    assign cmd.ready  = (state_reg == ST_IDLE);
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign ch_is_last = (ch_reg == CH_IDX_W'(CHANNELS - 1));

    // Pair of the current channel; a zero divisor acts as one
    assign pair_idx    = PAIR_IDX_W'(ch_reg >> 1);
    assign divisor_sel = (divisor_reg[pair_idx] == '0) ? DIV_W'(1) : divisor_reg[pair_idx];
    assign product     = PROD_W'(amp_reg[ch_reg] * sample_reg);

    assign div_req.start    = (state_reg == ST_DIVS);
    assign div_req.dividend = prod_reg;
    assign div_req.divisor  = divisor_sel;

    stp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Offset by the midpoint and clamp to the duty range
    assign level_sum = (PROD_W + 1)'(MID_LEVEL) + (PROD_W + 1)'(div_rsp.quotient);
    always_comb
    begin
        if (level_sum < 0)
            duty_sat = '0;
        else if (level_sum > (PROD_W + 1)'(DUTY_MAX))
            duty_sat = DUTY_W'(DUTY_MAX);
        else
            duty_sat = level_sum[DUTY_W-1:0];
    end

    // Sequencer: state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer: next state and output load
    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.kind == KIND_TICK))
                    state_next = ST_MUL;
            end
            ST_MUL:
                state_next = ST_DIVS;
            ST_DIVS:
                state_next = ST_DIVW;
            ST_DIVW:
            begin
                if (div_rsp.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Wait for a free output slot, then hand over the level
                if (!out_valid_reg || lvl.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ch_is_last ? ST_IDLE : ST_MUL;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_load_reg   <= '0;
            pulse_start_reg <= PULSE_W'(32);
            for (int i = 0; i < PAIR_COUNT; i++)
                divisor_reg[i] <= DIV_W'(512);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYNC_LOAD:   sync_load_reg   <= cfg_data[IDX_W-1:0];
                REG_PULSE_START: pulse_start_reg <= cfg_data[PULSE_W-1:0];
                REG_DIVISOR0:    divisor_reg[0]  <= cfg_data[DIV_W-1:0];
                REG_DIVISOR1:    divisor_reg[1]  <= cfg_data[DIV_W-1:0];
                REG_DIVISOR2:    divisor_reg[2]  <= cfg_data[DIV_W-1:0];
                REG_DIVISOR3:    divisor_reg[3]  <= cfg_data[DIV_W-1:0];
                REG_DIVISOR4:    divisor_reg[4]  <= cfg_data[DIV_W-1:0];
                REG_DIVISOR5:    divisor_reg[5]  <= cfg_data[DIV_W-1:0];
                default:         ;
            endcase
        end
    end

    // Phase index and amplitude store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
                amp_reg[i] <= '0;
        end
        else if (cmd_fire)
        begin
            unique case (cmd.kind)
                // The table spans the whole index range, so the add wraps by itself
                KIND_TICK: phase_reg <= phase_reg + 1'b1;
                KIND_SYNC: phase_reg <= sync_load_reg;
                KIND_AMP:
                begin
                    // Drop writes to channels beyond the last one
                    for (int i = 0; i < CHANNELS; i++)
                        if (cmd.channel == CH_W'(i))
                            amp_reg[i] <= cmd.amplitude;
                end
                default: ;
            endcase
        end
    end

    // Latch the sample and sync level of a tick, and the product in the multiply step
    always_ff @(posedge clk)
    begin
        if (cmd_fire && (cmd.kind == KIND_TICK))
        begin
            sample_reg <= sine_sample(phase_reg);
            sync_reg   <= ({1'b0, phase_reg} < pulse_start_reg);
        end
        if (state_reg == ST_MUL)
            prod_reg <= product;
    end

    // Channel counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ch_reg <= '0;
        else if (cmd_fire && (cmd.kind == KIND_TICK))
            ch_reg <= '0;
        else if (load_out && !ch_is_last)
            ch_reg <= ch_reg + 1'b1;
    end

    // Output register: hold until taken, reload in the same cycle it drains
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (lvl.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_channel_reg <= CH_W'(ch_reg);
            out_duty_reg    <= duty_sat;
            out_sync_reg    <= sync_reg;
            out_last_reg    <= ch_is_last;
        end
    end

    assign lvl.valid       = out_valid_reg;
    assign lvl.out_channel = out_channel_reg;
    assign lvl.duty        = out_duty_reg;
    assign lvl.sync_level  = out_sync_reg;
    assign lvl.last        = out_last_reg;

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.kind == KIND_TICK)) |=> (phase_reg == IDX_W'($past(phase_reg) + 1'b1)))
        else $error("phase index did not advance on a tick");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> (!out_valid_reg || lvl.ready))
        else $error("output register overwritten before it was taken");
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_last_reg == (out_channel_reg == CH_W'(CHANNELS - 1))))
        else $error("last flag does not match the final channel");
    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIVW))
        else $error("divider finished outside the wait step");

endmodule

`default_nettype wire

>>> src/stp_div.sv
// Bit-serial signed divider, one quotient bit a cycle, quotient truncated toward zero.
// Depends on stp_pkg for the request and response structs.
`default_nettype none

module stp_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire stp_pkg::div_req_t req,
    output stp_pkg::div_rsp_t      rsp
);
    import stp_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [PROD_W-1:0]   dvd_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    dsr_reg;
    logic                neg_reg;

    logic [DIV_W:0]      trial;
    logic                qbit;
    logic [DIV_W-1:0]    rem_next;
    logic [PROD_W-1:0]   mag;

    assign mag      = req.dividend[PROD_W-1] ? PROD_W'(-req.dividend) : PROD_W'(req.dividend);
    assign trial    = {rem_reg, dvd_reg[PROD_W-1]};
    assign qbit     = (trial >= {1'b0, dsr_reg});
    assign rem_next = qbit ? DIV_W'(trial - {1'b0, dsr_reg}) : DIV_W'(trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= mag;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            neg_reg <= req.dividend[PROD_W-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[PROD_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(dvd_reg) : $signed(dvd_reg);

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg) else $error("divider restarted while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("divider done without a run");
    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (dsr_reg != '0)) else $error("divider running on zero divisor");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the sine PWM level generator: drives command beats and register writes,
// predicts every level beat in a small scoreboard class and checks them in arrival order.
// Depends on stp_pkg, the channel interfaces in stp_if.sv and the block's RTL.

module tb_top;
    import stp_pkg::*;

    localparam int  LEVELS_PER_TICK = 12;
    localparam int  SETTLE_CYCLES   = 40;       // covers a trailing no-result command
    localparam int  HOLD_CYCLES     = 800;      // long receiver hold-off
    localparam int  RANDOM_PHASES   = 7;
    localparam int  RANDOM_TARGET   = 370;
    localparam int  DRAIN_LIMIT     = 50000;
    localparam int  RUN_LIMIT       = 5000000;  // time units, far above the slowest clean run
    localparam int  REPORT_LIMIT    = 40;
    localparam real TWO_PI          = 6.283185307179586;

    // Kind code that the block has no use for
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [CH_W-1:0]   out_channel;
        logic [DUTY_W-1:0] duty;
        logic              sync_level;
        logic              last;
    } level_beat_t;

    // Mirror of the generator: phase, amplitudes and registers, plus the
    // queue of level beats still due from the block.
    class level_scoreboard;
        level_beat_t             due_levels[$];
        int                      sine_lut [TABLE_SIZE];
        logic [IDX_W-1:0]        phase;
        logic signed [AMP_W-1:0] amp_store [LEVELS_PER_TICK];
        logic [IDX_W-1:0]        sync_load;
        logic [PULSE_W-1:0]      pulse_start;
        logic [DIV_W-1:0]        divisor [PAIR_COUNT];
        int                      n_mismatch;
        int                      n_checked;
        int                      n_ticks;
        int                      n_syncs;
        int                      n_amps;
        int                      n_ignored;

        function new();
            real r;
            // trunc(512*sin), nudged so exact entries do not fall just short
            for (int n = 0; n < TABLE_SIZE; n++)
            begin
                r = 512.0 * $sin(TWO_PI * n / TABLE_SIZE);
                sine_lut[n] = (r >= 0.0) ? $rtoi(r + 1.0e-6) : -$rtoi(1.0e-6 - r);
            end
            phase       = '0;
            sync_load   = '0;
            pulse_start = PULSE_W'(32);
            for (int c = 0; c < LEVELS_PER_TICK; c++)
                amp_store[c] = '0;
            for (int k = 0; k < PAIR_COUNT; k++)
                divisor[k] = DIV_W'(512);
            n_mismatch = 0;
            n_checked  = 0;
            n_ticks    = 0;
            n_syncs    = 0;
            n_amps     = 0;
            n_ignored  = 0;
        endfunction

        task report(string what);
            n_mismatch++;
            if (n_mismatch <= REPORT_LIMIT)
                $display("MISMATCH @%0t: %s", $time, what);
        endtask

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_SYNC_LOAD:   sync_load   = data[IDX_W-1:0];
                REG_PULSE_START: pulse_start = data[PULSE_W-1:0];
                default:         divisor[idx - REG_DIVISOR0] = data[DIV_W-1:0];
            endcase
        endfunction

        function void note_command(logic [KIND_W-1:0] kind, logic [CH_W-1:0] ch,
                                   logic signed [AMP_W-1:0] amp);
            level_beat_t beat;
            int          sample;
            int          divide_by;
            int          level;
            case (kind)
                KIND_SYNC:
                begin
                    phase = sync_load;
                    n_syncs++;
                end
                KIND_AMP:
                begin
                    if (ch < LEVELS_PER_TICK)
                    begin
                        amp_store[ch] = amp;
                        n_amps++;
                    end
                    else
                        n_ignored++;
                end
                KIND_TICK:
                begin
                    sample = sine_lut[phase];
                    for (int c = 0; c < LEVELS_PER_TICK; c++)
                    begin
                        divide_by = divisor[c / 2];
                        if (divide_by == 0)
                            divide_by = 1;
                        level = MID_LEVEL + (int'(amp_store[c]) * sample) / divide_by;
                        if (level < 0)
                            level = 0;
                        if (level > DUTY_MAX)
                            level = DUTY_MAX;
                        beat.out_channel = CH_W'(c);
                        beat.duty        = DUTY_W'(level);
                        beat.sync_level  = ({1'b0, phase} < pulse_start);
                        beat.last        = (c == LEVELS_PER_TICK - 1);
                        due_levels.push_back(beat);
                    end
                    phase = phase + 1'b1;
                    n_ticks++;
                end
                default: n_ignored++;
            endcase
        endfunction

        task check_level(logic [CH_W-1:0] ch, logic [DUTY_W-1:0] duty, logic sync_level,
                         logic last);
            level_beat_t want;
            n_checked++;
            if (due_levels.size() == 0)
            begin
                report($sformatf("level beat ch %0d duty %0d with nothing due", ch, duty));
                return;
            end
            want = due_levels.pop_front();
            if (ch !== want.out_channel)
                report($sformatf("out_channel %0d, want %0d", ch, want.out_channel));
            if (duty !== want.duty)
                report($sformatf("ch %0d duty %0d, want %0d", want.out_channel, duty, want.duty));
            if (sync_level !== want.sync_level)
                report($sformatf("ch %0d sync_level %0b, want %0b", want.out_channel,
                                 sync_level, want.sync_level));
            if (last !== want.last)
                report($sformatf("ch %0d last %0b, want %0b", want.out_channel, last, want.last));
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    stp_cmd_if cmd_ch ();
    stp_lvl_if lvl_ch ();

    level_scoreboard sb;

    int tx_idle_pct   = 36;
    int rx_idle_pct   = 36;
    int hold_requests = 0;   // bumped by the stimulus, served by the level sink
    int stim_count    = 0;   // commands that change the block's state or give results
    int reg_writes    = 0;
    int settings_used = 1;   // the reset settings count as the first

    sine_table_multichannel_pwm_levels #(
        .CHANNELS (LEVELS_PER_TICK)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .lvl       (lvl_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop: only reached if the block hangs or loses beats
    initial
    begin
        #(RUN_LIMIT);
        $display("timeout with %0d level beats still due", sb.due_levels.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Write one register at the falling edge; mirror it at the rising edge,
    // then drop the enable again.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
        reg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one command beat, idling at random first. Called at a falling edge;
    // returns at the falling edge after acceptance with valid still high, so the
    // next caller either holds it for a new beat or drops it.
    task automatic send_command(input logic [KIND_W-1:0] kind, input logic [CH_W-1:0] ch,
                                input logic signed [AMP_W-1:0] amp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.kind      <= kind;
        cmd_ch.channel   <= ch;
        cmd_ch.amplitude <= amp;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        sb.note_command(kind, ch, amp);
        @(negedge clk);
    endtask

    // Drop valid, wait for every due level beat, then let a trailing
    // no-result command finish before anything touches the registers.
    task automatic drain_levels();
        int waited;
        waited = 0;
        cmd_ch.valid <= 1'b0;
        while (sb.due_levels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write every register with a fresh value, extremes favoured
    task automatic configure_random();
        logic [CFG_DATA_W-1:0] value;
        for (int i = 0; i < 8; i++)
        begin
            if (CFG_IDX_W'(i) == REG_SYNC_LOAD)
            begin
                if ($urandom_range(3) == 0)
                    value = ($urandom_range(1) == 0) ? 12'd0 : 12'd63;
                else
                    value = CFG_DATA_W'($urandom);
            end
            else if (CFG_IDX_W'(i) == REG_PULSE_START)
            begin
                case ($urandom_range(5))
                    0:       value = 12'd0;
                    1:       value = 12'd64;
                    2:       value = 12'd127;
                    3:       value = CFG_DATA_W'($urandom);
                    default: value = CFG_DATA_W'($urandom_range(64));
                endcase
            end
            else
            begin
                case ($urandom_range(9))
                    0:       value = 12'd0;      // behaves as one
                    1:       value = 12'd1;
                    2:       value = 12'd4095;
                    3:       value = 12'd512;
                    4, 5, 6: value = CFG_DATA_W'($urandom_range(64, 1));
                    default: value = CFG_DATA_W'($urandom_range(4095, 1));
                endcase
            end
            write_register(CFG_IDX_W'(i), value);
        end
        settings_used++;
    endtask

    // One random command: mostly ticks and amplitude writes, some sync edges,
    // and a sprinkling of commands the block must drop.
    task automatic send_random_item();
        int                      pick;
        logic signed [AMP_W-1:0] amp;
        pick = $urandom_range(99);
        case ($urandom_range(9))
            0:       amp = 10'sh200;               // most negative
            1:       amp = 10'sd511;
            2:       amp = ($urandom_range(1) == 0) ? 10'sd500 : -10'sd500;
            default: amp = AMP_W'($urandom_range(1000) - 500);
        endcase
        if (pick < 50)
        begin
            send_command(KIND_TICK, CH_W'($urandom), AMP_W'($urandom));
            stim_count++;
        end
        else if (pick < 74)
        begin
            send_command(KIND_AMP, CH_W'($urandom_range(LEVELS_PER_TICK - 1)), amp);
            stim_count++;
        end
        else if (pick < 84)
        begin
            send_command(KIND_SYNC, CH_W'($urandom), AMP_W'($urandom));
            stim_count++;
        end
        else if (pick < 90)
            send_command(KIND_AMP, CH_W'($urandom_range(15, LEVELS_PER_TICK)), amp);
        else if (pick < 95)
            send_command(KIND_SPARE, CH_W'($urandom), AMP_W'($urandom));
        else
        begin
            // any ten-bit pattern, out-of-range amplitudes included
            send_command(KIND_AMP, CH_W'($urandom_range(LEVELS_PER_TICK - 1)),
                         AMP_W'($urandom));
            stim_count++;
        end
    endtask

    // Level sink: random ready, plus a long hold-off on request, counted here
    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        lvl_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_seen != hold_requests)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                lvl_ch.ready <= 1'b0;
            end
            else
                lvl_ch.ready <= ($urandom_range(99) >= rx_idle_pct) ? 1'b1 : 1'b0;
            @(posedge clk);
            if (lvl_ch.valid && lvl_ch.ready)
                sb.check_level(lvl_ch.out_channel, lvl_ch.duty, lvl_ch.sync_level, lvl_ch.last);
        end
    end

    // Stimulus
    initial
    begin
        int  phase_start;
        bit  paused;
        sb = new();
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.kind      = KIND_TICK;
        cmd_ch.channel   = '0;
        cmd_ch.amplitude = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: every divisor 512, sync pulse over the first half.
        // Load the amplitude extremes, then tick through a sync edge.
        send_command(KIND_AMP, 4'd0, 10'sd500);
        send_command(KIND_AMP, 4'd1, -10'sd500);
        send_command(KIND_AMP, 4'd2, 10'sh200);
        send_command(KIND_AMP, 4'd3, 10'sd511);
        send_command(KIND_AMP, 4'd4, 10'sd1);
        send_command(KIND_AMP, 4'd5, -10'sd1);
        send_command(KIND_AMP, 4'd11, -10'sd300);
        // beyond the last channel and the spare kind: both dropped silently
        send_command(KIND_AMP, 4'd15, 10'sd300);
        send_command(KIND_SPARE, 4'd7, 10'sh1FF);
        send_command(KIND_TICK, 4'd0, 10'sd0);
        send_command(KIND_TICK, 4'hF, 10'sh3FF);
        send_command(KIND_SYNC, 4'd0, 10'sd0);
        send_command(KIND_TICK, 4'd0, 10'sd0);
        stim_count += 11;

        // Jump to the positive peak with unit and largest divisors, sync never high
        drain_levels();
        write_register(REG_SYNC_LOAD, 12'd16);
        write_register(REG_PULSE_START, 12'd0);
        write_register(REG_DIVISOR0, 12'd1);
        write_register(REG_DIVISOR1, 12'd4095);
        settings_used++;
        send_command(KIND_SYNC, 4'd0, 10'sd0);
        send_command(KIND_TICK, 4'd0, 10'sd0);
        stim_count += 2;

        // Load the top index from an all-ones write and wrap; zero divisor acts as one
        drain_levels();
        write_register(REG_SYNC_LOAD, 12'hFFF);
        write_register(REG_PULSE_START, 12'd64);
        write_register(REG_DIVISOR0, 12'd0);
        settings_used++;
        send_command(KIND_SYNC, 4'd0, 10'sd0);
        send_command(KIND_TICK, 4'd0, 10'sd0);
        send_command(KIND_TICK, 4'd0, 10'sd0);
        send_command(KIND_TICK, 4'd0, 10'sd0);
        stim_count += 4;

        // Random phases, each under fresh register settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_levels();
            configure_random();
            // phase two runs with no idling on either side
            tx_idle_pct = (p == 2) ? 0 : 36;
            rx_idle_pct = (p == 2) ? 0 : 36;
            if (p == 3)
            begin
                // hold the sink off and offer sixteen ticks, which stalls the input
                hold_requests++;
                repeat (16)
                begin
                    send_command(KIND_TICK, CH_W'($urandom), AMP_W'($urandom));
                    stim_count++;
                end
            end
            phase_start = stim_count;
            paused      = 1'b0;
            while (stim_count - phase_start < RANDOM_TARGET / RANDOM_PHASES)
            begin
                if (p == 4 && !paused && stim_count - phase_start >= 30)
                begin
                    // pause the sender until the block has emptied
                    drain_levels();
                    paused = 1'b1;
                end
                send_random_item();
            end
        end

        drain_levels();
        if (sb.due_levels.size() != 0)
            sb.report($sformatf("%0d level beats never arrived", sb.due_levels.size()));

        $display("covered %0d ticks (%0d level beats checked), %0d sync edges, %0d amp writes",
                 sb.n_ticks, sb.n_checked, sb.n_syncs, sb.n_amps);
        $display("plus %0d dropped commands, %0d register writes over %0d settings, %0d mismatches",
                 sb.n_ignored, reg_writes, settings_used, sb.n_mismatch);
        if (sb.n_mismatch == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
